// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion forms shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_HOLDS(label, expr, msg)

`define ASSERT_IMPLIES(label, pre, post, msg)

`define ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// File: rtl/core/chca_pkg.sv
// ----------------------------------------------------------------------------
// chca_pkg
// Widths, constants, register codes and table entry type of the cell
// accumulator.
// ----------------------------------------------------------------------------
package chca_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ETA_W    = 10;
  localparam int PHI_W    = 6;
  localparam int LAYER_W  = 5;
  localparam int ID_W     = ETA_W + PHI_W + LAYER_W;
  localparam int EV_W     = 32;
  localparam int TIME_W   = 24;
  localparam int SUM_W    = 48;
  localparam int KEV_W    = 24;

  localparam int ACC_TH_W  = 16;
  localparam int REP_TH_W  = 20;
  localparam int MAX_REC_W = 7;
  localparam int LIM_W     = (CNT_W > MAX_REC_W) ? CNT_W : MAX_REC_W;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [ACC_TH_W-1:0]  ACC_TH_RST  = 16'd10;
  localparam logic [REP_TH_W-1:0]  REP_TH_RST  = 20'd1000;
  localparam logic [MAX_REC_W-1:0] MAX_REC_RST = 7'd64;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [KEV_W-1:0] KEV_MAX    = {KEV_W{1'b1}};
  // smallest eV sum whose keV value no longer fits in 24 bits
  localparam logic [SUM_W-1:0] KEV_SAT_EV = 48'd16777216000;

  // floor(x / 1000) = floor((x >> 3) * RECIP_125 >> RECIP_SHIFT) for x below KEV_SAT_EV
  localparam int QUO_Y_W     = 31;
  localparam int RECIP_W     = 32;
  localparam int PROD_W      = QUO_Y_W + RECIP_W;
  localparam int RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_125 = 32'd2199023256;

  localparam logic OP_HIT = 1'b0;
  localparam logic OP_END = 1'b1;

  typedef enum logic [1:0] {
    REG_ACCEPT_TH = 2'd0,
    REG_REPORT_TH = 2'd1,
    REG_MAX_REC   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]   cell_id;
    logic [SUM_W-1:0]  energy;
    logic [TIME_W-1:0] first_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [ID_W-1:0] pack_id(input logic [ETA_W-1:0]   eta,
                                              input logic [PHI_W-1:0]   phi,
                                              input logic [LAYER_W-1:0] layer);
    return {eta, phi, layer};
  endfunction

endpackage

// File: rtl/core/chca_if.sv
// ----------------------------------------------------------------------------
// chca_if
// Valid/ready channels of the cell accumulator: hit words in, record words out.
// ----------------------------------------------------------------------------
interface chca_hit_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [chca_pkg::ETA_W-1:0]    eta_index;
  logic [chca_pkg::PHI_W-1:0]    phi_index;
  logic [chca_pkg::LAYER_W-1:0]  depth_index;
  logic [chca_pkg::EV_W-1:0]     energy_ev;
  logic [chca_pkg::TIME_W-1:0]   hit_time;

  modport source (
    output valid, operation, eta_index, phi_index, depth_index, energy_ev, hit_time,
    input  ready
  );
  modport sink (
    input  valid, operation, eta_index, phi_index, depth_index, energy_ev, hit_time,
    output ready
  );
endinterface

interface chca_rec_if;
  logic                         valid;
  logic                         ready;
  logic [chca_pkg::ID_W-1:0]    cell_id;
  logic [chca_pkg::KEV_W-1:0]   energy_kev;
  logic [chca_pkg::TIME_W-1:0]  earliest_time;
  logic                         none_found;
  logic                         last;

  modport source (
    output valid, cell_id, energy_kev, earliest_time, none_found, last,
    input  ready
  );
  modport sink (
    input  valid, cell_id, energy_kev, earliest_time, none_found, last,
    output ready
  );
endinterface

// File: rtl/core/calorimeter_hit_cell_accumulator_core.sv
// ----------------------------------------------------------------------------
// calorimeter_hit_cell_accumulator_core
// Per-event cell table of calorimeter hits with thresholded end-of-event report.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the cell table sits in a single RAM whose
// read port is walked one entry at a time. A hit below the accept threshold
// is dropped as it is taken. A hit on a new cell reads every held cell, then
// appends it if the table has room; a hit matching a held cell reads up to it
// and writes the new sum back. An end-of-event word walks the table and
// waits while the record output stalls. A record word waits in an output
// register, so the next hit is taken while it is still unread. Records leave
// in table order; the final one carries last. After reset the table is empty
// and the block takes words at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calorimeter_hit_cell_accumulator_core (
  input  logic                          clk,
  input  logic                          rst,
  chca_hit_if.sink                      hits,
  chca_rec_if.source                    records,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chca_pkg::PADDR_W-1:0]  paddr,
  input  logic [chca_pkg::PDATA_W-1:0]  pwdata,
  output logic [chca_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HREAD,
    S_HCMP,
    S_HWRITE,
    S_APPEND,
    S_RREAD,
    S_REVAL,
    S_RMUL,
    S_RQUO,
    S_RDONE
  } state_t;

  state_t state;

  logic [chca_pkg::ACC_TH_W-1:0]  acc_th;
  logic [chca_pkg::REP_TH_W-1:0]  rep_th;
  logic [chca_pkg::MAX_REC_W-1:0] max_rec;

  logic [chca_pkg::CNT_W-1:0] count;
  logic [chca_pkg::CNT_W-1:0] scan;
  logic [chca_pkg::CNT_W-1:0] nrec;

  logic [chca_pkg::ID_W-1:0]   hit_id;
  logic [chca_pkg::EV_W-1:0]   hit_e;
  logic [chca_pkg::TIME_W-1:0] hit_t;
  chca_pkg::entry_t            upd;

  logic [chca_pkg::ID_W-1:0]    calc_id;
  logic [chca_pkg::TIME_W-1:0]  calc_t;
  logic                         calc_sat;
  logic [chca_pkg::QUO_Y_W-1:0] calc_y;
  logic [chca_pkg::PROD_W-1:0]  prod;

  logic                        pend_valid;
  logic [chca_pkg::ID_W-1:0]   pend_id;
  logic [chca_pkg::KEV_W-1:0]  pend_kev;
  logic [chca_pkg::TIME_W-1:0] pend_t;

  logic                        out_valid;
  logic [chca_pkg::ID_W-1:0]   out_id;
  logic [chca_pkg::KEV_W-1:0]  out_kev;
  logic [chca_pkg::TIME_W-1:0] out_t;
  logic                        out_none;
  logic                        out_last;

  logic                       ram_we;
  logic [chca_pkg::IDX_W-1:0] ram_waddr;
  logic [chca_pkg::IDX_W-1:0] ram_raddr;
  chca_pkg::entry_t           ram_wdata;
  chca_pkg::entry_t           ram_rdata;

  logic                        cfg_wr;
  chca_pkg::reg_idx_t          cfg_sel;
  logic                        in_take;
  logic                        out_free;
  logic                        out_load;
  logic                        lim_hit;
  logic                        id_match;
  logic [chca_pkg::SUM_W:0]    sum_wide;
  logic                        qual;
  logic [chca_pkg::KEV_W-1:0]  new_kev;
  logic [chca_pkg::ID_W-1:0]   in_id;
  logic                        rec_blank;
  logic                        none_word;
  logic                        rdone_go;

  chca_ram #(
    .WIDTH (chca_pkg::ENTRY_W),
    .DEPTH (chca_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = chca_pkg::reg_idx_t'(paddr[chca_pkg::PADDR_W-1:2]);

  always_comb begin
    unique case (cfg_sel)
      chca_pkg::REG_ACCEPT_TH: prdata = chca_pkg::PDATA_W'(acc_th);
      chca_pkg::REG_REPORT_TH: prdata = chca_pkg::PDATA_W'(rep_th);
      chca_pkg::REG_MAX_REC:   prdata = chca_pkg::PDATA_W'(max_rec);
      default:                 prdata = '0;
    endcase
  end

  assign hits.ready = (state == S_IDLE);
  assign in_take    = hits.valid && hits.ready;
  assign in_id      = chca_pkg::pack_id(hits.eta_index, hits.phi_index, hits.depth_index);

  assign records.valid         = out_valid;
  assign records.cell_id       = out_id;
  assign records.energy_kev    = out_kev;
  assign records.earliest_time = out_t;
  assign records.none_found    = out_none;
  assign records.last          = out_last;

  assign out_free = !out_valid || records.ready;
  assign out_load = out_free && (((state == S_RQUO) && pend_valid) || (state == S_RDONE));
  assign lim_hit  = chca_pkg::LIM_W'(nrec) >= chca_pkg::LIM_W'(max_rec);
  assign id_match = (ram_rdata.cell_id == hit_id);
  assign sum_wide = {1'b0, ram_rdata.energy} + (chca_pkg::SUM_W + 1)'(hit_e);
  assign qual     = ram_rdata.energy > chca_pkg::SUM_W'(rep_th);
  assign new_kev  = calc_sat ? chca_pkg::KEV_MAX
                             : prod[chca_pkg::RECIP_SHIFT +: chca_pkg::KEV_W];

  assign rec_blank = (records.cell_id == '0) && (records.energy_kev == '0) &&
                     (records.earliest_time == '0);
  assign none_word = records.valid && records.none_found;
  assign rdone_go  = (state == S_RDONE) && out_free;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan[chca_pkg::IDX_W-1:0];
    ram_raddr = scan[chca_pkg::IDX_W-1:0];
    ram_wdata = upd;
    unique case (state)
      S_HWRITE: begin
        ram_we = 1'b1;
      end
      S_APPEND: begin
        ram_we    = (count < chca_pkg::DEPTH_CNT);
        ram_waddr = count[chca_pkg::IDX_W-1:0];
        ram_wdata = '{cell_id: hit_id, energy: chca_pkg::SUM_W'(hit_e), first_time: hit_t};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_th     <= chca_pkg::ACC_TH_RST;
      rep_th     <= chca_pkg::REP_TH_RST;
      max_rec    <= chca_pkg::MAX_REC_RST;
      state      <= S_IDLE;
      count      <= '0;
      scan       <= '0;
      nrec       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_sel)
          chca_pkg::REG_ACCEPT_TH: acc_th  <= pwdata[chca_pkg::ACC_TH_W-1:0];
          chca_pkg::REG_REPORT_TH: rep_th  <= pwdata[chca_pkg::REP_TH_W-1:0];
          chca_pkg::REG_MAX_REC:   max_rec <= pwdata[chca_pkg::MAX_REC_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && records.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            scan  <= '0;
            nrec  <= '0;
            hit_id <= in_id;
            hit_e  <= hits.energy_ev;
            hit_t  <= hits.hit_time;
            if (hits.operation == chca_pkg::OP_END) begin
              state <= S_RREAD;
            end else if (hits.energy_ev >= chca_pkg::EV_W'(acc_th)) begin
              state <= (count == '0) ? S_APPEND : S_HREAD;
            end
          end
        end
        S_HREAD: begin
          state <= S_HCMP;
        end
        S_HCMP: begin
          if (id_match) begin
            upd.cell_id    <= hit_id;
            upd.energy     <= sum_wide[chca_pkg::SUM_W] ? chca_pkg::SUM_MAX
                                                        : sum_wide[chca_pkg::SUM_W-1:0];
            upd.first_time <= (hit_t < ram_rdata.first_time) ? hit_t
                                                              : ram_rdata.first_time;
            state          <= S_HWRITE;
          end else if (scan + 1'b1 == count) begin
            state <= S_APPEND;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_HREAD;
          end
        end
        S_HWRITE: begin
          state <= S_IDLE;
        end
        S_APPEND: begin
          if (count < chca_pkg::DEPTH_CNT) begin
            count <= count + 1'b1;
          end
          state <= S_IDLE;
        end
        S_RREAD: begin
          state <= (scan == count || lim_hit) ? S_RDONE : S_REVAL;
        end
        S_REVAL: begin
          if (qual) begin
            calc_id  <= ram_rdata.cell_id;
            calc_t   <= ram_rdata.first_time;
            calc_sat <= ram_rdata.energy >= chca_pkg::KEV_SAT_EV;
            calc_y   <= ram_rdata.energy[chca_pkg::QUO_Y_W+2:3];
            state    <= S_RMUL;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_RREAD;
          end
        end
        S_RMUL: begin
          prod  <= chca_pkg::PROD_W'(calc_y) * chca_pkg::PROD_W'(chca_pkg::RECIP_125);
          state <= S_RQUO;
        end
        S_RQUO: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid <= 1'b1;
              out_id    <= pend_id;
              out_kev   <= pend_kev;
              out_t     <= pend_t;
              out_none  <= 1'b0;
              out_last  <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_id    <= calc_id;
            pend_kev   <= new_kev;
            pend_t     <= calc_t;
            nrec       <= nrec + 1'b1;
            scan       <= scan + 1'b1;
            state      <= S_RREAD;
          end
        end
        S_RDONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_id     <= pend_valid ? pend_id : '0;
            out_kev    <= pend_valid ? pend_kev : '0;
            out_t      <= pend_valid ? pend_t : '0;
            out_none   <= !pend_valid;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            count      <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_HOLDS(a_count_bound, count <= chca_pkg::DEPTH_CNT, "cell count beyond table depth")
  `ASSERT_IMPLIES(a_idle_no_pend, state == S_IDLE, !pend_valid, "record left pending in idle")
  `ASSERT_IMPLIES(a_none_last, none_word, records.last && rec_blank, "empty report word malformed")
  `ASSERT_NEXT(a_report_clears, rdone_go, (count == '0) && (state == S_IDLE), "table kept after report")

endmodule

// File: rtl/core/chca_ram.sv
// ----------------------------------------------------------------------------
// chca_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module chca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calorimeter cell accumulator. Hit and
// end-of-event words go in over the valid/ready channel. A cell table kept
// in the bench predicts every record word, and each record is compared field
// by field in arrival order. The run walks through phases with different
// thresholds and record limits. Sender gaps and receiver stalls differ from
// phase to phase. A directed opening covers the field extremes, ignored hits,
// the report boundary and keV saturation.
// Random events follow: small cell pools, a few that overfill the table,
// empty events and stray hits.
// ----------------------------------------------------------------------------
module tb;
  import chca_pkg::*;

  localparam int LIMIT         = 3_000_000;
  localparam int SETTLE        = 200;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 30;
  localparam int REG_UNUSED    = 3;

  localparam logic [31:0] ACCEPT_SET[PHASES] = '{10, 0, 65535, 500, 100, 0, 20, 10};
  localparam logic [31:0] REPORT_SET[PHASES] = '{1000, 0, 1048575, 5000, 2000, 1048575, 0, 1000};
  localparam logic [31:0] RECORD_SET[PHASES] = '{64, 64, 0, 1, 127, 3, 2, 64};

  typedef struct packed {
    logic               operation;
    logic [ETA_W-1:0]   eta;
    logic [PHI_W-1:0]   phi;
    logic [LAYER_W-1:0] depth;
    logic [EV_W-1:0]    energy;
    logic [TIME_W-1:0]  hit_time;
  } hit_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   cell_id;
    logic [KEV_W-1:0]  energy_kev;
    logic [TIME_W-1:0] earliest_time;
    logic              none_found;
    logic              last;
  } record_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  hit_word_t send_word = '0;
  logic      send_valid = 1'b0;
  logic      take_ready = 1'b0;

  chca_hit_if hit_ch();
  chca_rec_if rec_ch();

  assign hit_ch.valid       = send_valid;
  assign hit_ch.operation   = send_word.operation;
  assign hit_ch.eta_index   = send_word.eta;
  assign hit_ch.phi_index   = send_word.phi;
  assign hit_ch.depth_index = send_word.depth;
  assign hit_ch.energy_ev   = send_word.energy;
  assign hit_ch.hit_time    = send_word.hit_time;
  assign rec_ch.ready       = take_ready;

  calorimeter_hit_cell_accumulator_core dut (
    .clk     (clk),
    .rst     (rst),
    .hits    (hit_ch),
    .records (rec_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  hit_word_t pending[$];
  record_t   records_due[$];
  record_t   want_rec;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        cycles = 0;
  int        errors = 0;
  logic      calm;

  assign calm = (cycles % 256) < 32;

  logic [ACC_TH_W-1:0]  accept_th = ACC_TH_RST;
  logic [REP_TH_W-1:0]  report_th = REP_TH_RST;
  logic [MAX_REC_W-1:0] max_rec = MAX_REC_RST;

  logic [ID_W-1:0]   cell_ids[TABLE_DEPTH];
  logic [SUM_W-1:0]  cell_sum[TABLE_DEPTH];
  logic [TIME_W-1:0] cell_first[TABLE_DEPTH];
  int                cell_count = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] due);
    if (got !== due) report_mismatch($sformatf("%s got %0h want %0h", name, got, due));
  endtask

  function automatic void accumulate_hit(input hit_word_t w);
    logic [ID_W-1:0]  id;
    logic [SUM_W:0]   total;
    if (w.energy < EV_W'(accept_th)) return;
    id = {w.eta, w.phi, w.depth};
    for (int i = 0; i < cell_count; i++) begin
      if (cell_ids[i] == id) begin
        total = {1'b0, cell_sum[i]} + (SUM_W + 1)'(w.energy);
        cell_sum[i] = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
        if (w.hit_time < cell_first[i]) cell_first[i] = w.hit_time;
        return;
      end
    end
    if (cell_count < TABLE_DEPTH) begin
      cell_ids[cell_count] = id;
      cell_sum[cell_count] = SUM_W'(w.energy);
      cell_first[cell_count] = w.hit_time;
      cell_count++;
    end
  endfunction

  function automatic void close_event();
    int              quota;
    int              sent;
    logic [SUM_W-1:0] kev;
    record_t         r;
    quota = (int'(max_rec) > TABLE_DEPTH) ? TABLE_DEPTH : int'(max_rec);
    sent = 0;
    for (int i = 0; i < cell_count && sent < quota; i++) begin
      if (cell_sum[i] > SUM_W'(report_th)) begin
        kev = cell_sum[i] / 1000;
        r.cell_id = cell_ids[i];
        r.energy_kev = (kev > SUM_W'(KEV_MAX)) ? KEV_MAX : kev[KEV_W-1:0];
        r.earliest_time = cell_first[i];
        r.none_found = 1'b0;
        r.last = 1'b0;
        records_due.push_back(r);
        sent++;
      end
    end
    cell_count = 0;
    if (sent == 0) begin
      r = '0;
      r.none_found = 1'b1;
    end else begin
      r = records_due.pop_back();
    end
    r.last = 1'b1;
    records_due.push_back(r);
  endfunction

  function automatic logic [EV_W-1:0] pick_energy();
    case ($urandom_range(5))
      0: return $urandom_range(40);
      1: return $urandom_range(3000);
      2: return $urandom_range(70000);
      3: return $urandom_range(2000000);
      4: return $urandom | 32'hFFF0_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    if ($urandom_range(3) == 0) return TIME_W'($urandom_range(3));
    return TIME_W'($urandom);
  endfunction

  function automatic hit_word_t rand_hit();
    hit_word_t w;
    w.operation = OP_HIT;
    w.eta = ETA_W'($urandom);
    w.phi = PHI_W'($urandom);
    w.depth = LAYER_W'($urandom);
    w.energy = pick_energy();
    w.hit_time = pick_time();
    return w;
  endfunction

  function automatic hit_word_t make_hit(input logic [ETA_W-1:0] eta,
                                         input logic [PHI_W-1:0] phi,
                                         input logic [LAYER_W-1:0] depth,
                                         input logic [EV_W-1:0] energy,
                                         input logic [TIME_W-1:0] t);
    hit_word_t w;
    w.operation = OP_HIT;
    w.eta = eta;
    w.phi = phi;
    w.depth = depth;
    w.energy = energy;
    w.hit_time = t;
    return w;
  endfunction

  function automatic void push_end();
    hit_word_t w;
    w = rand_hit();
    w.operation = OP_END;
    pending.push_back(w);
  endfunction

  function automatic int queue_event(input int n_hits, input int n_cells);
    hit_word_t pool[$];
    hit_word_t w;
    for (int i = 0; i < n_cells; i++) pool.push_back(rand_hit());
    for (int i = 0; i < n_hits; i++) begin
      if (i < n_cells) w = pool[i];
      else w = pool[$urandom_range(n_cells - 1)];
      if ($urandom_range(19) == 0) w = rand_hit();
      w.energy = pick_energy();
      w.hit_time = pick_time();
      pending.push_back(w);
    end
    push_end();
    return n_hits + 1;
  endfunction

  task automatic write_reg(input int idx, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      int'(REG_ACCEPT_TH): accept_th = value[ACC_TH_W-1:0];
      int'(REG_REPORT_TH): report_th = value[REP_TH_W-1:0];
      int'(REG_MAX_REC):   max_rec = value[MAX_REC_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && send_valid && hit_ch.ready) begin
      if (send_word.operation == OP_HIT) accumulate_hit(send_word);
      else close_event();
    end
    if (rst) begin
      send_valid <= 1'b0;
    end else if (!send_valid || hit_ch.ready) begin
      if (pending.size() != 0 && (calm || $urandom_range(99) >= send_idle_pct)) begin
        send_word <= pending.pop_front();
        send_valid <= 1'b1;
      end else begin
        send_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) take_ready <= 1'b0;
    else take_ready <= calm || ($urandom_range(99) >= recv_stall_pct);
    if (!rst && rec_ch.valid && take_ready) begin
      if (records_due.size() == 0) begin
        report_mismatch("record word with no record due");
      end else begin
        want_rec = records_due.pop_front();
        check_field("cell_id", 32'(rec_ch.cell_id), 32'(want_rec.cell_id));
        check_field("energy_kev", 32'(rec_ch.energy_kev), 32'(want_rec.energy_kev));
        check_field("earliest_time", 32'(rec_ch.earliest_time), 32'(want_rec.earliest_time));
        check_field("none_found", 32'(rec_ch.none_found), 32'(want_rec.none_found));
        check_field("last", 32'(rec_ch.last), 32'(want_rec.last));
      end
    end
  end

  initial begin
    int budget;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (phase != 0) begin
        write_reg(int'(REG_ACCEPT_TH), ACCEPT_SET[phase]);
        write_reg(int'(REG_REPORT_TH), REPORT_SET[phase]);
        write_reg(int'(REG_MAX_REC), RECORD_SET[phase]);
      end
      if (phase == 2) write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      budget = 0;
      if (phase == 0) begin
        pending.push_back(make_hit(10'd1023, 6'd63, 5'd31, 32'hFFFF_FFFF, 24'hFF_FFFF));
        pending.push_back(make_hit(10'd1023, 6'd63, 5'd31, 32'hFFFF_FFFF, 24'd7));
        pending.push_back(make_hit(10'd1023, 6'd63, 5'd31, 32'hFFFF_FFFF, 24'd7));
        pending.push_back(make_hit(10'd1023, 6'd63, 5'd31, 32'hFFFF_FFFF, 24'd20));
        pending.push_back(make_hit(10'd1023, 6'd63, 5'd31, 32'd5, 24'd0));
        pending.push_back(make_hit(10'd0, 6'd0, 5'd0, 32'd9, 24'd0));
        pending.push_back(make_hit(10'd0, 6'd0, 5'd0, 32'd10, 24'd0));
        pending.push_back(make_hit(10'd0, 6'd0, 5'd0, 32'd990, 24'd3));
        pending.push_back(make_hit(10'd1, 6'd2, 5'd3, 32'd1001, 24'd100));
        pending.push_back(make_hit(10'd512, 6'd32, 5'd16, 32'd999999, 24'd1));
        pending.push_back(make_hit(10'd1, 6'd2, 5'd3, 32'd0, 24'd0));
        push_end();
        push_end();
        budget = pending.size();
      end
      if (phase == 1 || phase == 4) budget += queue_event(75, 70);
      while (budget < PHASE_ITEMS) begin
        case ($urandom_range(9))
          0: budget += queue_event(0, 0);
          1: begin
            pending.push_back(rand_hit());
            budget++;
          end
          default: budget += queue_event($urandom_range(1, 14), $urandom_range(1, 8));
        endcase
      end
      while (pending.size() != 0 || send_valid || records_due.size() != 0) @(negedge clk);
      repeat (SETTLE) @(posedge clk);
    end
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/chca_pkg.sv
rtl/core/chca_if.sv
rtl/core/chca_ram.sv
rtl/core/calorimeter_hit_cell_accumulator_core.sv
bench/tb.sv
